/* design/wtsc_pkg.sv */
`default_nettype none

package wtsc_pkg;

    // Request kinds carried in the op field.
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_REG_WRITE  = 2'd1;
    localparam logic [1:0] OP_WAVE_WRITE = 2'd2;

    // Channel register offsets.
    localparam logic [2:0] REG_DAC      = 3'd0;
    localparam logic [2:0] REG_VOLUME   = 3'd2;
    localparam logic [2:0] REG_FREQ_LO  = 3'd3;
    localparam logic [2:0] REG_FREQ_HI  = 3'd4;

    localparam int TIMER_W    = 14;
    localparam int POS_W      = 5;
    localparam int FREQ_W     = 11;
    localparam int WAVE_BYTES = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] reg_offset;
        logic [3:0] wave_index;
        logic [7:0] write_data;
        logic [7:0] elapsed_cycles;
    } item_t;

    typedef struct packed {
        logic [3:0]       sample;
        logic [POS_W-1:0] wave_position;
    } result_t;

    // Period in cycles: (2048 - frequency) * 4, which always fits in 14 bits.
    function automatic logic [TIMER_W-1:0] period_of(input logic [FREQ_W-1:0] freq);
        logic [FREQ_W:0] steps;
        steps = 12'd2048 - {1'b0, freq};
        return {steps, 2'b00};
    endfunction

    // Volume code 0 mutes, 1 is full level, 2 is half, 3 is a quarter.
    function automatic logic [3:0] vol_scale(input logic [3:0] nib, input logic [1:0] vol);
        logic [3:0] res;
        res = 4'd0;
        case (vol)
            2'd0: res = 4'd0;
            2'd1: res = nib;
            2'd2: res = {1'b0, nib[3:1]};
            default: res = {2'b00, nib[3:2]};
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/wtsc_in_reg.sv */
`default_nettype none

module wtsc_in_reg (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wtsc_pkg::item_t   s_item,
    output logic              item_valid,
    output wtsc_pkg::item_t   item,
    input  wire               item_consume
);

    logic            valid_reg;
    logic            valid_next;
    wtsc_pkg::item_t item_reg;

    // The slot takes a new request when it is empty or drained this cycle.
    assign s_ready = !valid_reg || item_consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* design/wtsc_core.sv */
`default_nettype none

module wtsc_core (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                item_valid,
    input  wtsc_pkg::item_t    item,
    output logic               item_consume,
    input  wire                out_free,
    output logic               res_valid,
    output wtsc_pkg::result_t  res
);

    localparam int TW = wtsc_pkg::TIMER_W;
    localparam int PW = wtsc_pkg::POS_W;
    localparam int FW = wtsc_pkg::FREQ_W;

    logic [7:0]    wave_reg [wtsc_pkg::WAVE_BYTES];
    logic [TW-1:0] timer_reg, timer_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          en_reg, en_next;
    logic          dac_reg, dac_next;
    logic [1:0]    vol_reg, vol_next;
    logic [FW-1:0] freq_reg, freq_next;
    logic          trig_reg, trig_next;

    logic          tick_fire;
    logic          reg_fire;
    logic          wave_fire;
    logic [TW-1:0] period;
    logic [TW-1:0] t_start;
    logic [TW-1:0] t_count;
    logic [TW-1:0] t_reload;
    logic [TW-1:0] n_ext;
    logic [7:0]    overshoot;
    logic [PW-1:0] pos_tick;
    logic          en_tick;
    logic [7:0]    cur_byte;
    logic [3:0]    nib;

    assign tick_fire    = item_valid && (item.op == wtsc_pkg::OP_TICK) && out_free;
    assign reg_fire     = item_valid && (item.op == wtsc_pkg::OP_REG_WRITE);
    assign wave_fire    = item_valid && (item.op == wtsc_pkg::OP_WAVE_WRITE);
    assign item_consume = item_valid && ((item.op != wtsc_pkg::OP_TICK) || out_free);

    // Tick datapath: trigger load, countdown, then reload and position advance on expiry.
    always_comb begin
        period    = wtsc_pkg::period_of(freq_reg);
        t_start   = trig_reg ? period : timer_reg;
        n_ext     = {{(TW-8){1'b0}}, item.elapsed_cycles};
        overshoot = 8'd0;
        t_count   = t_start;
        if (t_start != '0) begin
            if (t_start < n_ext) begin
                overshoot = item.elapsed_cycles - t_start[7:0];
                t_count   = '0;
            end else begin
                t_count = t_start - n_ext;
            end
        end
        t_reload = t_count;
        pos_tick = pos_reg;
        if (t_count == '0) begin
            t_reload = (period > {{(TW-8){1'b0}}, overshoot}) ?
                       period - {{(TW-8){1'b0}}, overshoot} : '0;
            pos_tick = pos_reg + {{(PW-1){1'b0}}, 1'b1};
        end
        en_tick  = en_reg || trig_reg;
        cur_byte = wave_reg[pos_tick[PW-1:1]];
        nib      = pos_tick[0] ? cur_byte[3:0] : cur_byte[7:4];
    end

    always_comb begin
        timer_next = timer_reg;
        pos_next   = pos_reg;
        en_next    = en_reg;
        dac_next   = dac_reg;
        vol_next   = vol_reg;
        freq_next  = freq_reg;
        trig_next  = trig_reg;
        if (tick_fire) begin
            timer_next = t_reload;
            pos_next   = pos_tick;
            en_next    = en_tick;
            trig_next  = 1'b0;
        end
        if (reg_fire) begin
            unique case (item.reg_offset)
                wtsc_pkg::REG_DAC:     dac_next = item.write_data[7];
                wtsc_pkg::REG_VOLUME:  vol_next = item.write_data[6:5];
                wtsc_pkg::REG_FREQ_LO: freq_next = {freq_reg[FW-1:8], item.write_data};
                wtsc_pkg::REG_FREQ_HI: begin
                    trig_next = item.write_data[7];
                    freq_next = {item.write_data[2:0], freq_reg[7:0]};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            pos_reg   <= '0;
            en_reg    <= 1'b0;
            dac_reg   <= 1'b0;
            vol_reg   <= 2'd0;
            freq_reg  <= '0;
            trig_reg  <= 1'b0;
        end else begin
            timer_reg <= timer_next;
            pos_reg   <= pos_next;
            en_reg    <= en_next;
            dac_reg   <= dac_next;
            vol_reg   <= vol_next;
            freq_reg  <= freq_next;
            trig_reg  <= trig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wtsc_pkg::WAVE_BYTES; i++) begin
                wave_reg[i] <= 8'd0;
            end
        end else if (wave_fire) begin
            wave_reg[item.wave_index] <= item.write_data;
        end
    end

    assign res_valid         = tick_fire;
    assign res.wave_position = pos_tick;
    assign res.sample        = (en_tick && dac_reg) ? wtsc_pkg::vol_scale(nib, vol_reg) : 4'd0;

`ifndef NO_ASSERTIONS
    a_trig_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire && trig_reg |=> en_reg && !trig_reg)
        else $error("pending trigger did not enable the channel");

    a_en_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(en_reg))
        else $error("channel enable dropped without reset");

    a_pos_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !tick_fire |=> $stable(pos_reg))
        else $error("sample position moved without a tick");

    a_consume_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire |-> item_consume)
        else $error("tick produced a result without being consumed");
`endif

endmodule

`default_nettype wire

/* design/wtsc_out_reg.sv */
`default_nettype none

module wtsc_out_reg (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                res_valid,
    input  wtsc_pkg::result_t  res,
    output logic               out_free,
    output logic               m_valid,
    input  wire                m_ready,
    output wtsc_pkg::result_t  m_res
);

    logic              valid_reg;
    logic              valid_next;
    wtsc_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

/* design/wave_table_sound_channel.sv */
// Wave-table sound channel. Each request is a tick of N elapsed cycles, a
// channel register write or a wave-table byte write; only ticks return a
// result (the scaled sample and the sample position after the tick). The
// block takes one request per cycle unless a tick waits for the output
// register: a request passes an input register, the whole timer and sample
// update runs combinationally against the channel state, and the result
// lands in an output register, which drives the result port. A tick waits
// in the input register only while the output register is full and not
// being taken; writes never wait.
`default_nettype none

module wave_table_sound_channel (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [1:0]  s_op,
    input  wire [2:0]  s_reg_offset,
    input  wire [3:0]  s_wave_index,
    input  wire [7:0]  s_write_data,
    input  wire [7:0]  s_elapsed_cycles,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [3:0] m_sample,
    output logic [4:0] m_wave_position
);

    wtsc_pkg::item_t   s_item;
    wtsc_pkg::item_t   item;
    wtsc_pkg::result_t res;
    wtsc_pkg::result_t m_res;
    logic              item_valid;
    logic              item_consume;
    logic              out_free;
    logic              res_valid;

    // Gather the request fields into one bundle for the input register.
    assign s_item.op             = s_op;
    assign s_item.reg_offset     = s_reg_offset;
    assign s_item.wave_index     = s_wave_index;
    assign s_item.write_data     = s_write_data;
    assign s_item.elapsed_cycles = s_elapsed_cycles;

    wtsc_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .item_valid   (item_valid),
        .item         (item),
        .item_consume (item_consume)
    );

    // The core holds all channel state and the wave table, and retires the
    // request held in the input register; a tick waits for a free output register.
    wtsc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (item_valid),
        .item         (item),
        .item_consume (item_consume),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res)
    );

    wtsc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_sample        = m_res.sample;
    assign m_wave_position = m_res.wave_position;

endmodule

`default_nettype wire
